// ===== design/assert_macros.svh =====
// assertion macros included by the engine top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent and consequent in the same cycle
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// consequent in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== design/hpte_pkg.sv =====
// types, codes and constants of the hashed page table engine
`default_nettype none

package hpte_pkg;

    localparam int WAYS   = 8;
    localparam int SLOT_W = 3;
    localparam int W0_W   = 48;
    localparam int AVA_LO = 7;

    typedef logic [W0_W-1:0] word0_t;
    typedef word0_t [WAYS-1:0] row_t;

    typedef enum logic {
        OP_INSTALL = 1'b0,
        OP_REMOVE  = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        OUT_FILLED    = 3'd0,
        OUT_REPLACED  = 3'd1,
        OUT_EVICTED   = 3'd2,
        OUT_REMOVED   = 3'd3,
        OUT_NOT_FOUND = 3'd4
    } outcome_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPDATE
    } state_t;

    typedef struct packed {
        outcome_t            outcome;
        logic [SLOT_W-1:0]   slot;
        logic                write;
    } match_t;

    localparam word0_t W0_VALID_BIT = 48'h0000_0000_0001;
    localparam word0_t W0_LOCAL_BIT = 48'h0000_0000_0008;

    // wimg memory coherence, referenced and changed
    localparam logic [63:0] W1_BASE_BITS  = 64'h0000_0000_0000_0190;
    localparam logic [63:0] W1_RO_BITS    = 64'h8000_0000_0000_0002;
    localparam logic [63:0] W1_NOEXEC_BIT = 64'h0000_0000_0000_0004;
    localparam logic [63:0] W1_CI_BITS    = 64'h0000_0000_0000_0028;

    // only the low 16 bits of the hash can survive the group mask
    function automatic logic [15:0] hash16(input logic [63:0] va);
        return va[27:12] ^ va[43:28];
    endfunction

endpackage

`default_nettype wire

// ===== design/hashed_page_table_engine.sv =====
// top level of the hashed page table engine: group memory, sequencer and result register
`default_nettype none

// Hashed page table of NUM_GROUPS groups of eight entries; each input word is an
// install or a remove and gives exactly one result word. After reset a clearing
// pass zeroes the group memory one row a cycle, with s_tready low. For an item,
// the accept cycle reads the whole eight-slot row of its group from the single
// group memory, and in the compare state the engine compares the slots, writes
// the row back and loads the result register. A result waiting in that register
// does not block the next accept and read; the compare cycle waits only while the
// register is still full.
module hashed_page_table_engine #(
    parameter int NUM_GROUPS = 2048
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    // virt_addr[63:0], phys_addr[127:64], writable[128], executable[129],
    // cache_inhibit[130], local_entry[131], timebase_low[138:132], zero fill
    input  wire logic [143:0]  s_tdata,
    // operation[0]
    input  wire logic [0:0]    s_tuser,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    // group_index[10:0], slot_index[13:11], entry_word0[61:14],
    // entry_word1[125:62], invalidate_addr[189:126], zero fill
    output logic [191:0]       m_tdata,
    // outcome[2:0]
    output logic [2:0]         m_tuser
);

    `include "assert_macros.svh"

    localparam int GW = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
    localparam logic [15:0] GROUP_MASK = 16'(NUM_GROUPS - 1);
    localparam logic [GW-1:0] LAST_ROW = GW'(NUM_GROUPS - 1);

    hpte_pkg::state_t state_reg, state_next;
    logic [GW-1:0]    clr_cnt_reg, clr_cnt_next;

    logic             s_accept;
    logic             out_load;

    // request held for the compare cycle
    hpte_pkg::op_t    op_reg;
    logic [63:0]      va_reg;
    logic [63:0]      pa_reg;
    logic             wr_reg, ex_reg, ci_reg, local_reg;
    logic [6:0]       tb_reg;
    logic [15:0]      grp_reg;

    logic [15:0]      grp_in;

    // group memory
    hpte_pkg::row_t   group_mem [NUM_GROUPS];
    hpte_pkg::row_t   rdata_reg;
    logic             mem_we;
    logic [GW-1:0]    mem_waddr;
    hpte_pkg::row_t   mem_wdata;

    hpte_pkg::word0_t w0;
    logic [63:0]      w1;
    logic [2:0]       victim;
    hpte_pkg::match_t res;
    hpte_pkg::row_t   new_row;

    logic             out_valid_reg;
    logic [191:0]     out_data_reg;
    logic [2:0]       out_user_reg;

    assign s_tready = (state_reg == hpte_pkg::ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign grp_in   = hpte_pkg::hash16(s_tdata[63:0]) & GROUP_MASK;

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            op_reg    <= hpte_pkg::op_t'(s_tuser[0]);
            va_reg    <= s_tdata[63:0];
            pa_reg    <= s_tdata[127:64];
            wr_reg    <= s_tdata[128];
            ex_reg    <= s_tdata[129];
            ci_reg    <= s_tdata[130];
            local_reg <= s_tdata[131];
            tb_reg    <= s_tdata[138:132];
            grp_reg   <= grp_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            group_mem[mem_waddr] <= mem_wdata;
        end
        if (s_accept) begin
            rdata_reg <= group_mem[grp_in[GW-1:0]];
        end
    end

    always_comb begin
        w0 = {va_reg[63:23], 7'b0} | hpte_pkg::W0_VALID_BIT;
        if (local_reg) begin
            w0 = w0 | hpte_pkg::W0_LOCAL_BIT;
        end
        w1 = {pa_reg[63:12], 12'h000} | hpte_pkg::W1_BASE_BITS;
        if (!wr_reg) begin
            w1 = w1 | hpte_pkg::W1_RO_BITS;
        end
        if (!ex_reg) begin
            w1 = w1 | hpte_pkg::W1_NOEXEC_BIT;
        end
        if (ci_reg) begin
            w1 = w1 | hpte_pkg::W1_CI_BITS;
        end
    end

    assign victim = tb_reg[2:0] ^ tb_reg[6:4];

    hpte_slot_select u_select (
        .op      (op_reg),
        .row     (rdata_reg),
        .w0      (w0),
        .victim  (victim),
        .res     (res),
        .new_row (new_row)
    );

    always_comb begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        mem_we       = 1'b0;
        mem_waddr    = grp_reg[GW-1:0];
        mem_wdata    = new_row;
        out_load     = 1'b0;
        case (state_reg)
            hpte_pkg::ST_CLEAR: begin
                mem_we       = 1'b1;
                mem_waddr    = clr_cnt_reg;
                mem_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == LAST_ROW) begin
                    state_next = hpte_pkg::ST_IDLE;
                end
            end
            hpte_pkg::ST_IDLE: begin
                if (s_accept) begin
                    state_next = hpte_pkg::ST_UPDATE;
                end
            end
            hpte_pkg::ST_UPDATE: begin
                if (!out_valid_reg || m_tready) begin
                    out_load   = 1'b1;
                    mem_we     = res.write;
                    state_next = hpte_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = hpte_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= hpte_pkg::ST_CLEAR;
            clr_cnt_reg <= '0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_user_reg <= res.outcome;
            out_data_reg <= {2'b00,
                             (op_reg == hpte_pkg::OP_REMOVE) ? {va_reg[63:12], 12'h000} : 64'h0,
                             (op_reg == hpte_pkg::OP_INSTALL) ? w1 : 64'h0,
                             w0,
                             res.slot,
                             grp_reg[10:0]};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    // an accepted word always reaches the compare cycle next
    `ASSERT_NEXT(a_accept_to_update, aclk, aresetn, s_accept,
        state_reg == hpte_pkg::ST_UPDATE)
    // the memory is never written while waiting for a word
    `ASSERT_SAME(a_no_write_idle, aclk, aresetn, state_reg == hpte_pkg::ST_IDLE, !mem_we)
    // a fresh result only follows a compare cycle
    `ASSERT_SAME(a_result_from_update, aclk, aresetn, $rose(m_tvalid),
        $past(state_reg) == hpte_pkg::ST_UPDATE)
    // a remove that misses leaves the row untouched
    `ASSERT_SAME(a_miss_no_write, aclk, aresetn,
        out_load && res.outcome == hpte_pkg::OUT_NOT_FOUND, !mem_we)

endmodule

`default_nettype wire

// ===== design/hpte_slot_select.sv =====
// slot search over one group row and the updated row to write back
`default_nettype none

module hpte_slot_select (
    input  wire hpte_pkg::op_t               op,
    input  wire hpte_pkg::row_t              row,
    input  wire hpte_pkg::word0_t            w0,
    input  wire logic [hpte_pkg::SLOT_W-1:0] victim,
    output hpte_pkg::match_t                 res,
    output hpte_pkg::row_t                   new_row
);

    logic [hpte_pkg::WAYS-1:0]     cond;
    logic [hpte_pkg::SLOT_W-1:0]   sel;
    logic                          found;

    always_comb begin
        for (int i = 0; i < hpte_pkg::WAYS; i++) begin
            if (op == hpte_pkg::OP_INSTALL) begin
                cond[i] = !row[i][0] ||
                    (row[i][hpte_pkg::W0_W-1:hpte_pkg::AVA_LO] ==
                     w0[hpte_pkg::W0_W-1:hpte_pkg::AVA_LO]);
            end else begin
                cond[i] = (row[i] == w0);
            end
        end
    end

    // lowest slot wins
    always_comb begin
        sel   = '0;
        found = 1'b0;
        for (int i = hpte_pkg::WAYS - 1; i >= 0; i--) begin
            if (cond[i]) begin
                sel   = hpte_pkg::SLOT_W'(i);
                found = 1'b1;
            end
        end
    end

    always_comb begin
        if (op == hpte_pkg::OP_INSTALL) begin
            res.write = 1'b1;
            if (found) begin
                res.slot    = sel;
                res.outcome = row[sel][0] ? hpte_pkg::OUT_REPLACED : hpte_pkg::OUT_FILLED;
            end else begin
                res.slot    = victim;
                res.outcome = hpte_pkg::OUT_EVICTED;
            end
        end else begin
            res.write   = found;
            res.slot    = found ? sel : '0;
            res.outcome = found ? hpte_pkg::OUT_REMOVED : hpte_pkg::OUT_NOT_FOUND;
        end
    end

    always_comb begin
        new_row = row;
        new_row[res.slot] = (op == hpte_pkg::OP_INSTALL) ? w0 : '0;
    end

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// testbench of the hashed page table engine: directed and random requests against a predictor
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int GROUP_COUNT    = 2048;
    localparam int TABLE_DEPTH    = GROUP_COUNT * hpte_pkg::WAYS;
    localparam int RANDOM_ITEMS   = 1600;
    localparam int STALL_ITEMS    = 48;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 20;
    // clearing pass after reset plus the long receiver hold, with margin
    localparam int WATCHDOG_LIMIT = 10000;
    localparam int MAX_REPORTS    = 10;

    typedef struct packed {
        hpte_pkg::op_t op;
        logic [63:0]   va;
        logic [63:0]   pa;
        logic          wr;
        logic          ex;
        logic          ci;
        logic          loc;
        logic [6:0]    tb;
    } pte_req_t;

    typedef struct packed {
        hpte_pkg::outcome_t outcome;
        logic [10:0]        group;
        logic [2:0]         slot;
        logic [47:0]        w0;
        logic [63:0]        w1;
        logic [63:0]        inval;
    } pte_result_t;

    typedef struct packed {
        logic [63:0] va;
        logic        loc;
    } mapping_t;

    logic          aclk     = 1'b0;
    logic          aresetn  = 1'b0;
    logic          s_tvalid = 1'b0;
    logic          s_tready;
    logic [143:0]  s_tdata  = '0;
    logic [0:0]    s_tuser  = '0;
    logic          m_tvalid;
    logic          m_tready = 1'b0;
    logic [191:0]  m_tdata;
    logic [2:0]    m_tuser;

    // predictor copy of the group memory
    logic [47:0]   pte_w0 [TABLE_DEPTH];
    logic [63:0]   pte_w1 [TABLE_DEPTH];

    pte_result_t   results_due [$];
    mapping_t      live_maps [$];
    int            mismatches   = 0;
    int            quiet_cycles = 0;
    bit            no_idle      = 1'b0;
    bit            hold_req     = 1'b0;

    hashed_page_table_engine #(
        .NUM_GROUPS(GROUP_COUNT)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 aclk = ~aclk;

    function automatic pte_result_t predict_pte_update(input pte_req_t r);
        pte_result_t res;
        logic [63:0] h;
        logic [40:0] ava;
        int          base;
        bit          found;
        res   = '0;
        found = 1'b0;
        ava   = r.va[63:23];
        res.w0 = {ava, 7'b0} | hpte_pkg::W0_VALID_BIT;
        if (r.loc)
            res.w0 = res.w0 | hpte_pkg::W0_LOCAL_BIT;
        h = ((r.va >> 12) & 64'hffff) ^ ((r.va >> 28) & 64'h7f_ffff_ffff);
        h = (h & 64'(GROUP_COUNT - 1)) % 64'(GROUP_COUNT);
        res.group = h[10:0];
        base = int'(h) * hpte_pkg::WAYS;
        if (r.op == hpte_pkg::OP_INSTALL) begin
            res.w1 = {r.pa[63:12], 12'h000} | hpte_pkg::W1_BASE_BITS;
            if (!r.wr)
                res.w1 = res.w1 | hpte_pkg::W1_RO_BITS;
            if (!r.ex)
                res.w1 = res.w1 | hpte_pkg::W1_NOEXEC_BIT;
            if (r.ci)
                res.w1 = res.w1 | hpte_pkg::W1_CI_BITS;
            res.outcome = hpte_pkg::OUT_EVICTED;
            for (int i = 0; i < hpte_pkg::WAYS; i++) begin
                if (!found) begin
                    if (!pte_w0[base + i][0]) begin
                        res.outcome = hpte_pkg::OUT_FILLED;
                        res.slot    = 3'(i);
                        found       = 1'b1;
                    end else if (pte_w0[base + i][47:7] == ava) begin
                        res.outcome = hpte_pkg::OUT_REPLACED;
                        res.slot    = 3'(i);
                        found       = 1'b1;
                    end
                end
            end
            // no free or matching slot: victim from the timebase
            if (!found)
                res.slot = r.tb[2:0] ^ r.tb[6:4];
            pte_w0[base + res.slot] = res.w0;
            pte_w1[base + res.slot] = res.w1;
        end else begin
            res.outcome = hpte_pkg::OUT_NOT_FOUND;
            for (int i = 0; i < hpte_pkg::WAYS; i++) begin
                if (!found && pte_w0[base + i][0] && pte_w0[base + i] == res.w0) begin
                    pte_w0[base + i] = '0;
                    res.slot    = 3'(i);
                    res.outcome = hpte_pkg::OUT_REMOVED;
                    found       = 1'b1;
                end
            end
            res.inval = {r.va[63:12], 12'h000};
        end
        return res;
    endfunction

    // address whose hash lands in grp, with the given abbreviated address
    function automatic logic [63:0] va_in_group(input logic [10:0] grp, input logic [40:0] ava,
                                                input logic [11:0] offs);
        logic [63:0] v;
        v = {ava, 11'b0, offs};
        v[22:12] = grp ^ v[38:28];
        return v;
    endfunction

    // flags are {local, cache inhibit, executable, writable}
    function automatic pte_req_t make_req(input hpte_pkg::op_t op, input logic [63:0] va,
                                          input logic [63:0] pa, input logic [3:0] flags,
                                          input logic [6:0] tb);
        pte_req_t r;
        r.op  = op;
        r.va  = va;
        r.pa  = pa;
        r.wr  = flags[0];
        r.ex  = flags[1];
        r.ci  = flags[2];
        r.loc = flags[3];
        r.tb  = tb;
        return r;
    endfunction

    // valid stays high after the handshake; the next call or the caller decides
    task automatic send_req(input pte_req_t r);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, r.tb, r.loc, r.ci, r.ex, r.wr, r.pa, r.va};
        s_tuser  <= r.op;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        results_due.push_back(predict_pte_update(r));
    endtask

    task automatic wait_all_results();
        s_tvalid <= 1'b0;
        while (results_due.size() != 0) @(posedge aclk);
    endtask

    task automatic test_directed();
        logic [10:0] grp;
        grp = 11'h2a5;
        send_req(make_req(hpte_pkg::OP_INSTALL, 64'h0, 64'h0, 4'b0000, 7'd0));
        send_req(make_req(hpte_pkg::OP_INSTALL, '1, '1, 4'b1111, 7'h7f));
        send_req(make_req(hpte_pkg::OP_REMOVE, 64'h0, 64'h0, 4'b0000, 7'd0));
        // already gone
        send_req(make_req(hpte_pkg::OP_REMOVE, 64'h0, '1, 4'b1111, 7'h7f));
        // same address but local bit differs
        send_req(make_req(hpte_pkg::OP_REMOVE, '1, '1, 4'b0000, 7'h7f));
        send_req(make_req(hpte_pkg::OP_REMOVE, '1, 64'h0, 4'b1000, 7'd0));
        for (int k = 0; k < hpte_pkg::WAYS; k++)
            send_req(make_req(hpte_pkg::OP_INSTALL,
                              va_in_group(grp, 41'(k + 1), 12'($urandom)),
                              {$urandom, $urandom}, 4'(k), 7'($urandom)));
        send_req(make_req(hpte_pkg::OP_INSTALL, va_in_group(grp, 41'd4, 12'hfff), '1,
                          4'b1010, 7'd0));
        // full group: victims chosen from the timebase
        send_req(make_req(hpte_pkg::OP_INSTALL, va_in_group(grp, '1, 12'h0), 64'h0,
                          4'b0101, 7'h7f));
        send_req(make_req(hpte_pkg::OP_INSTALL, va_in_group(grp, 41'h155_5555_5555, 12'h0),
                          {$urandom, $urandom}, 4'b1111, 7'h35));
        send_req(make_req(hpte_pkg::OP_REMOVE, va_in_group(grp, 41'd3, 12'h123), 64'h0,
                          4'b0000, 7'd0));
        send_req(make_req(hpte_pkg::OP_INSTALL, va_in_group(grp, 41'h0ab_cdef_0123, 12'h0),
                          {$urandom, $urandom}, 4'b1001, 7'd9));
    endtask

    task automatic test_random_mix();
        logic [10:0] hot [6];
        pte_req_t    r;
        mapping_t    m;
        hot[0] = 11'h000;
        hot[1] = 11'h7ff;
        for (int i = 2; i < 6; i++)
            hot[i] = 11'($urandom_range(0, GROUP_COUNT - 1));
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // every fourth block of a hundred runs with no idling at all
            no_idle = ((n / 100) % 4 == 3);
            r.op  = ($urandom_range(0, 99) < 60) ? hpte_pkg::OP_INSTALL : hpte_pkg::OP_REMOVE;
            r.pa  = {$urandom, $urandom};
            r.wr  = 1'($urandom);
            r.ex  = 1'($urandom);
            r.ci  = 1'($urandom);
            r.loc = 1'($urandom);
            r.tb  = 7'($urandom_range(0, 127));
            if (live_maps.size() > 0 &&
                $urandom_range(0, 99) < ((r.op == hpte_pkg::OP_REMOVE) ? 75 : 25)) begin
                m = live_maps[$urandom_range(0, live_maps.size() - 1)];
                r.va = {m.va[63:12], 12'($urandom)};
                if (r.op == hpte_pkg::OP_REMOVE)
                    r.loc = m.loc;
            end else if ($urandom_range(0, 99) < 80) begin
                r.va = va_in_group(hot[$urandom_range(0, 5)], 41'({$urandom, $urandom}),
                                   12'($urandom));
            end else begin
                r.va = {$urandom, $urandom};
            end
            send_req(r);
            if (r.op == hpte_pkg::OP_INSTALL) begin
                m.va  = r.va;
                m.loc = r.loc;
                live_maps.push_back(m);
                if (live_maps.size() > 48)
                    void'(live_maps.pop_front());
            end
        end
        no_idle = 1'b0;
    endtask

    task automatic test_backpressure();
        pte_req_t r;
        wait_all_results();
        hold_req = 1'b1;
        no_idle  = 1'b1;
        for (int n = 0; n < STALL_ITEMS; n++) begin
            // installs into one group; each odd item instead removes the install before it half the time
            if (n % 2 == 0 || $urandom_range(0, 1) == 0) begin
                r = make_req(hpte_pkg::OP_INSTALL,
                             va_in_group(11'h35a, 41'({$urandom, $urandom}), 12'($urandom)),
                             {$urandom, $urandom}, 4'($urandom), 7'($urandom));
            end else begin
                r.op = hpte_pkg::OP_REMOVE;
            end
            send_req(r);
        end
        no_idle = 1'b0;
        wait_all_results();
    endtask

    initial begin
        foreach (pte_w0[i]) begin
            pte_w0[i] = '0;
            pte_w1[i] = '0;
        end
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_random_mix();
        test_backpressure();
        wait_all_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0 && results_due.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // result side: random stalls per word, and one long hold when asked
    initial begin
        int stall;
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end
            stall = no_idle ? 0 : $urandom_range(0, 14);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        pte_result_t got;
        pte_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.outcome = hpte_pkg::outcome_t'(m_tuser);
            got.group   = m_tdata[10:0];
            got.slot    = m_tdata[13:11];
            got.w0      = m_tdata[61:14];
            got.w1      = m_tdata[125:62];
            got.inval   = m_tdata[189:126];
            if (results_due.size() == 0) begin
                if (mismatches < MAX_REPORTS)
                    $display("unexpected result word: outcome %0d group %h slot %0d",
                             got.outcome, got.group, got.slot);
                mismatches++;
            end else begin
                want = results_due.pop_front();
                if (got.outcome !== want.outcome || got.group !== want.group ||
                    got.slot !== want.slot || got.w0 !== want.w0 ||
                    got.w1 !== want.w1 || got.inval !== want.inval) begin
                    if (mismatches < MAX_REPORTS) begin
                        $display("mismatch at %0t: outcome %0d/%0d group %h/%h slot %0d/%0d",
                                 $realtime, want.outcome, got.outcome, want.group, got.group,
                                 want.slot, got.slot);
                        $display("  word0 %h/%h word1 %h/%h inval %h/%h",
                                 want.w0, got.w0, want.w1, got.w1, want.inval, got.inval);
                    end
                    mismatches++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
